@@ design/gst_pkg.sv @@
// ----------------------------------------------------------------------------
// Group soft threshold package
// Shared constants for the group soft threshold unit: data widths, the
// fixed-point format and the reset values of parameters and registers.
// ----------------------------------------------------------------------------
package gst_pkg;

  // Width of one element and of the weight and lambda words.
  localparam int unsigned DATA_W = 32;

  // Fractional bits of the Q16.16 and Q0.16 formats.
  localparam int unsigned FRAC_W = 16;

  // Default buffer depth, in elements.
  localparam int unsigned MAX_GROUP_DEFAULT = 64;

  // Reset value of lambda: 1.0 in Q16.16.
  localparam logic [DATA_W-1:0] LAMBDA_RESET = 32'h0001_0000;

  // Scale factor used when the threshold is zero: just below 1.0 in Q0.16.
  localparam logic [FRAC_W-1:0] FACTOR_MAX = 16'hFFFF;

endpackage

@@ design/group_soft_threshold_unit.sv @@
// ----------------------------------------------------------------------------
// Group soft threshold unit
// Block soft thresholding (group lasso proximal operator) over a stream of
// contiguous groups of signed Q16.16 elements.
//
// Each element that fits in the buffer is accepted, squared on the shared
// multiplier and accumulated; an element beyond the buffer is only accepted.
// When a group closes the unit forms the threshold (multiply, then saturate),
// runs the digit-by-digit square root, makes one compare and, unless the
// group is zeroed or the threshold is zero, runs restoring division for the
// 16-bit scale factor. Each result then goes through buffer read, multiply,
// load and hand-over, and the hand-over waits while out_stall is held. The
// 33 x 33 multiplier is shared by the square, threshold and result steps;
// the square root and divider each do one compare-subtract step at a time.
// in_stall is high whenever the unit is not idle, so only one element is in flight.
// ----------------------------------------------------------------------------
module group_soft_threshold_unit #(
  parameter int unsigned MAX_GROUP = gst_pkg::MAX_GROUP_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration
  input  logic                       cfg_write_en,
  input  logic [gst_pkg::DATA_W-1:0] cfg_write_data,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [gst_pkg::DATA_W-1:0] elem_value,
  input  logic [gst_pkg::DATA_W-1:0] group_weight,
  input  logic                       elem_last,
  // Output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [gst_pkg::DATA_W-1:0] out_value,
  output logic                       out_last,
  output logic                       group_zeroed,
  output logic                       group_overflow
);

  import gst_pkg::*;

  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);
  localparam int unsigned MW = DATA_W + 1;
  localparam int unsigned SW = 2 * DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_THR,
    ST_THR_SAT,
    ST_SQRT,
    ST_CMP,
    ST_DIV,
    ST_EM_RD,
    ST_EM_MUL,
    ST_EM_OUT,
    ST_EM_WAIT
  } state_t;

  state_t state;

  // Configuration and group state.
  logic [DATA_W-1:0]        lambda;
  logic [CW-1:0]            count;
  logic [SW-1:0]            square_sum;
  logic                     overflow_seen;

  // Latched input transaction.
  logic signed [DATA_W-1:0] op_value;
  logic [DATA_W-1:0]        weight_reg;
  logic                     last_reg;

  // Shared multiplier and its registered product.
  logic signed [MW-1:0]     mul_a;
  logic signed [MW-1:0]     mul_b;
  logic signed [2*MW-1:0]   mul_full;
  logic [SW-1:0]            prod;

  // Square root, threshold and divider registers.
  logic [SW-1:0]            sq_x;
  logic [SW-1:0]            sq_res;
  logic [SW-1:0]            sq_bit;
  logic [DATA_W-1:0]        thr;
  logic [DATA_W-1:0]        div_rem;
  logic [3:0]               div_cnt;
  logic [FRAC_W-1:0]        factor;
  logic                     zeroed;

  // Emission index and buffer.
  logic [CW-1:0]            em_idx;
  logic [DATA_W-1:0]        group_buffer [MAX_GROUP];
  logic signed [DATA_W-1:0] rd_data;

  // Combinational helpers.
  logic                     in_accept;
  logic                     has_room;
  logic [SW:0]              sum_ext;
  logic [SW-1:0]            sq_trial;
  logic                     sq_take;
  logic [DATA_W-1:0]        norm;
  logic [DATA_W:0]          div_shift;
  logic                     div_take;
  logic                     em_final;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign has_room  = (count < CW'(MAX_GROUP));

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state)
      ST_SQ: begin
        mul_a = MW'(op_value);
        mul_b = MW'(op_value);
      end
      ST_THR: begin
        mul_a = $signed({1'b0, lambda});
        mul_b = $signed({1'b0, weight_reg});
      end
      ST_EM_MUL: begin
        mul_a = MW'(rd_data);
        mul_b = $signed({{(MW-FRAC_W){1'b0}}, factor});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Saturating accumulate of the square.
  assign sum_ext = {1'b0, square_sum} + {1'b0, prod};

  // One step of the digit-by-digit square root.
  assign sq_trial = sq_res + sq_bit;
  assign sq_take  = (sq_x >= sq_trial);
  assign norm     = sq_res[DATA_W-1:0];

  // One step of the restoring divider.
  assign div_shift = {div_rem, 1'b0};
  assign div_take  = (div_shift >= {1'b0, norm});

  assign em_final = ((em_idx + CW'(1)) == count);

  // Group buffer: written on accept while there is room, read at the emission index.
  always_ff @(posedge clk) begin
    if (in_accept && has_room) begin
      group_buffer[count[AW-1:0]] <= elem_value;
    end
    rd_data <= group_buffer[em_idx[AW-1:0]];
  end

  // Sequencer, datapath registers and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      lambda        <= LAMBDA_RESET;
      count         <= '0;
      square_sum    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        lambda <= cfg_write_data;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            op_value   <= elem_value;
            weight_reg <= group_weight;
            last_reg   <= elem_last;
            if (has_room) begin
              state <= ST_SQ;
            end else begin
              overflow_seen <= 1'b1;
              if (elem_last) begin
                state <= ST_THR;
              end
            end
          end
        end

        ST_SQ: begin
          prod  <= mul_full[SW-1:0];
          state <= ST_ACC;
        end

        ST_ACC: begin
          square_sum <= sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
          count      <= count + CW'(1);
          state      <= last_reg ? ST_THR : ST_IDLE;
        end

        ST_THR: begin
          prod  <= mul_full[SW-1:0];
          state <= ST_THR_SAT;
        end

        // Threshold in Q16.16, saturated, and start of the square root.
        ST_THR_SAT: begin
          thr    <= (prod[SW-1:DATA_W+FRAC_W] != '0) ? {DATA_W{1'b1}}
                                                    : prod[DATA_W+FRAC_W-1:FRAC_W];
          sq_x   <= square_sum;
          sq_res <= '0;
          sq_bit <= {2'b01, {(SW-2){1'b0}}};
          state  <= ST_SQRT;
        end

        ST_SQRT: begin
          if (sq_take) begin
            sq_x   <= sq_x - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            state <= ST_CMP;
          end
        end

        // Decide between scaling and zeroing the group.
        ST_CMP: begin
          em_idx <= '0;
          if (norm > thr) begin
            zeroed <= 1'b0;
            if (thr == '0) begin
              factor <= FACTOR_MAX;
              state  <= ST_EM_RD;
            end else begin
              div_rem <= norm - thr;
              div_cnt <= '0;
              state   <= ST_DIV;
            end
          end else begin
            zeroed <= 1'b1;
            factor <= '0;
            state  <= ST_EM_RD;
          end
        end

        // Quotient bits shift into the factor register, most significant first.
        ST_DIV: begin
          if (div_take) begin
            div_rem <= DATA_W'(div_shift - {1'b0, norm});
          end else begin
            div_rem <= div_shift[DATA_W-1:0];
          end
          factor  <= {factor[FRAC_W-2:0], div_take};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) begin
            state <= ST_EM_RD;
          end
        end

        ST_EM_RD: begin
          state <= ST_EM_MUL;
        end

        ST_EM_MUL: begin
          prod  <= mul_full[SW-1:0];
          state <= ST_EM_OUT;
        end

        // Arithmetic shift of the product gives the floor of the scaled value.
        ST_EM_OUT: begin
          out_value      <= zeroed ? '0 : $signed(prod[DATA_W+FRAC_W-1:FRAC_W]);
          out_last       <= em_final;
          group_zeroed   <= zeroed;
          group_overflow <= overflow_seen;
          out_valid      <= 1'b1;
          state          <= ST_EM_WAIT;
        end

        ST_EM_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (em_final) begin
              count         <= '0;
              square_sum    <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              em_idx <= em_idx + CW'(1);
              state  <= ST_EM_RD;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // No new transaction is taken while a result is on offer.
  a_no_accept_during_output: assert property (
    @(posedge clk) disable iff (rst) out_valid |-> in_stall
  ) else $error("input accepted while a result was pending");

  // The element count never passes the buffer depth.
  a_count_bounded: assert property (
    @(posedge clk) disable iff (rst) count <= CW'(MAX_GROUP)
  ) else $error("element count beyond buffer depth");

  // Handing over the final result returns the unit to an empty, idle group.
  a_group_closes: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_last) |=>
      (count == '0 && !overflow_seen && !in_stall)
  ) else $error("group state not cleared after last result");

  // A zeroed group gives only zero values.
  a_zeroed_values: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && group_zeroed) |-> (out_value == '0)
  ) else $error("nonzero value in a zeroed group");

endmodule

@@ dv/group_soft_threshold_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Group soft threshold checker
// Watches the configuration port and both channels of the unit. It keeps its
// own copy of lambda and of the group being gathered, and works out the
// thresholded elements when a group closes. Each output transaction is then
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module group_soft_threshold_checker #(
  parameter int unsigned MAX_GROUP = gst_pkg::MAX_GROUP_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [gst_pkg::DATA_W-1:0]        cfg_write_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [gst_pkg::DATA_W-1:0] elem_value,
  input  logic [gst_pkg::DATA_W-1:0]        group_weight,
  input  logic                              elem_last,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [gst_pkg::DATA_W-1:0] out_value,
  input  logic                              out_last,
  input  logic                              group_zeroed,
  input  logic                              group_overflow,
  output int                                mismatch_count,
  output int                                results_owed
);

  import gst_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     zeroed;
    logic                     overflow;
  } thresholded_t;

  // Shadow of the group being gathered and of the lambda register.
  logic signed [DATA_W-1:0] group_buf [MAX_GROUP];
  int unsigned              buffered;
  logic [63:0]              square_total;
  logic                     dropped;
  logic [DATA_W-1:0]        lambda_copy;

  // Thresholded elements still to come out of the unit, oldest first.
  thresholded_t thresholded_q [$];
  int           errors = 0;

  // Floor of the square root of a 64-bit value, two bits per step.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] probe;
    root  = '0;
    rem   = x;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Buffer one element; on the closing element predict the whole group.
  task automatic threshold_group(input logic signed [DATA_W-1:0] v,
                                 input logic [DATA_W-1:0] weight,
                                 input logic closing);
    logic signed [63:0] wide;
    logic [63:0]        mag;
    logic [64:0]        total;
    logic [63:0]        thr;
    logic [63:0]        norm;
    logic signed [63:0] factor;
    logic signed [63:0] prod;
    logic               zero_all;
    thresholded_t       res;
    if (buffered < MAX_GROUP) begin
      wide  = v;
      mag   = (wide < 0) ? -wide : wide;
      total = {1'b0, square_total} + {1'b0, mag * mag};
      square_total = total[64] ? '1 : total[63:0];
      group_buf[buffered] = v;
      buffered++;
    end else begin
      dropped = 1'b1;
    end
    if (closing) begin
      // Threshold is lambda times weight in Q16.16, saturated to 32 bits.
      thr = ({32'b0, lambda_copy} * {32'b0, weight}) >> FRAC_W;
      if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
      norm     = floor_sqrt(square_total);
      zero_all = !(norm > thr);
      factor   = '0;
      if (!zero_all) begin
        factor = ((norm - thr) << FRAC_W) / norm;
        if (factor > 64'hFFFF) factor = {48'b0, FACTOR_MAX};
      end
      for (int unsigned k = 0; k < buffered; k++) begin
        wide         = group_buf[k];
        prod         = wide * factor;
        res.value    = DATA_W'(prod >>> FRAC_W);
        res.last     = (k + 1 == buffered);
        res.zeroed   = zero_all;
        res.overflow = dropped;
        thresholded_q.push_back(res);
      end
      buffered     = 0;
      square_total = '0;
      dropped      = 1'b0;
    end
  endtask

  task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
      errors++;
    end
  endtask

  // Follow every transaction on the three ports at the clock edge.
  always @(posedge clk) begin
    thresholded_t want;
    if (rst) begin
      buffered     = 0;
      square_total = '0;
      dropped      = 1'b0;
      lambda_copy  = LAMBDA_RESET;
      thresholded_q.delete();
    end else begin
      if (cfg_write_en) lambda_copy = cfg_write_data;
      if (out_valid && !out_stall) begin
        if (thresholded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value 0x%08h last %0b",
                   $time, out_value, out_last);
          errors++;
        end else begin
          want = thresholded_q.pop_front();
          compare_field("out_value", want.value, out_value);
          compare_field("out_last", {31'b0, want.last}, {31'b0, out_last});
          compare_field("group_zeroed", {31'b0, want.zeroed}, {31'b0, group_zeroed});
          compare_field("group_overflow", {31'b0, want.overflow}, {31'b0, group_overflow});
        end
      end
      if (in_valid && !in_stall) threshold_group(elem_value, group_weight, elem_last);
    end
    mismatch_count <= errors;
    results_owed   <= thresholded_q.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Group soft threshold testbench
// Drives groups of Q16.16 elements into the unit under several lambda
// settings: a short directed set of corner cases, then random groups of
// mostly small sizes with a few full and overflowing ones. Both channels
// pause in random bursts. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  import gst_pkg::*;

  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 65;
  localparam int unsigned SETTLE      = 16;

  logic                     clk            = 1'b0;
  logic                     rst            = 1'b1;
  logic                     cfg_write_en   = 1'b0;
  logic [DATA_W-1:0]        cfg_write_data = '0;
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] elem_value     = '0;
  logic [DATA_W-1:0]        group_weight   = '0;
  logic                     elem_last      = 1'b0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;
  logic                     group_zeroed;
  logic                     group_overflow;

  int          mismatch_count;
  int          results_owed;
  int unsigned items_sent  = 0;
  logic        in_idle_en  = 1'b1;
  logic        out_idle_en = 1'b1;
  logic [1:0]  stall_left  = '0;

  always #6 clk = ~clk;

  group_soft_threshold_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .elem_value    (elem_value),
    .group_weight  (group_weight),
    .elem_last     (elem_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_last      (out_last),
    .group_zeroed  (group_zeroed),
    .group_overflow(group_overflow)
  );

  group_soft_threshold_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .elem_value    (elem_value),
    .group_weight  (group_weight),
    .elem_last     (elem_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_last      (out_last),
    .group_zeroed  (group_zeroed),
    .group_overflow(group_overflow),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // Output back-pressure: random bursts of out_stall, counted down in stall_left.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= '0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1'b1;
    end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= 2'($urandom_range(0, 2));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one element and hold it until the transaction completes.
  task automatic send_element(input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] weight,
                              input logic closing);
    in_valid     <= 1'b1;
    elem_value   <= v;
    group_weight <= weight;
    elem_last    <= closing;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Let every predicted result come out, then give the unit time to go idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_lambda(input logic [DATA_W-1:0] value);
    wait_idle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // A group of random elements at a random scale, closed by a random weight.
  task automatic random_group(input int unsigned len);
    int unsigned       scale;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] weight;
    scale = $urandom_range(0, 24);
    for (int unsigned k = 0; k < len; k++) begin
      v = $signed($urandom()) >>> (($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : scale);
      case ($urandom_range(0, 9))
        0:       weight = '0;
        1:       weight = $urandom();
        default: weight = $urandom() >> $urandom_range(8, 31);
      endcase
      send_element(v, weight, k + 1 == len);
    end
  endtask

  initial begin
    logic [DATA_W-1:0] lambda_val;
    int unsigned       phase_start;
    int unsigned       len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed corner cases under the reset value of lambda.
    send_element(32'h0000_0000, 32'h1234_5678, 1'b1);   // zero norm
    send_element(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);   // zero threshold
    send_element(32'h8000_0000, 32'h0000_0000, 1'b1);
    repeat (3) send_element(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 32'h0001_0000, 1'b1);   // square sum saturates
    send_element(32'h0003_0000, 32'h0000_0000, 1'b0);
    send_element(32'hFFFC_0000, 32'h0000_0000, 1'b0);
    send_element(32'h0000_0001, 32'h0001_0000, 1'b1);   // scaled, negative floor
    send_element(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_element(32'h0001_0000, 32'h0002_0000, 1'b1);   // norm below threshold
    send_element(32'h0005_0000, 32'h0005_0000, 1'b1);   // norm equal to threshold

    // Largest lambda: the threshold saturates, or is zero with a zero weight.
    write_lambda(32'hFFFF_FFFF);
    send_element(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_element(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);

    // Zero lambda: every group with a nonzero norm keeps almost its full size.
    write_lambda(32'h0000_0000);
    send_element($urandom(), $urandom(), 1'b0);
    send_element($urandom(), $urandom(), 1'b0);
    send_element($urandom(), 32'hFFFF_FFFF, 1'b1);

    // Random groups, one lambda setting per phase; the last phase runs flat out.
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0:       lambda_val = LAMBDA_RESET;
        1:       lambda_val = $urandom();
        2:       lambda_val = 32'h0000_8000;
        3:       lambda_val = $urandom() >> $urandom_range(8, 20);
        4:       lambda_val = 32'hFFFF_FFFF;
        default: lambda_val = $urandom() >> 12;
      endcase
      write_lambda(lambda_val);
      in_idle_en  = (p + 1 < PHASES) && ($urandom_range(0, 3) != 0);
      out_idle_en <= (p + 1 < PHASES) && ($urandom_range(0, 3) != 0);
      phase_start = items_sent;
      // One full group and one that overflows the buffer, early in the run.
      if (p == 1) random_group(MAX_GROUP_DEFAULT + $urandom_range(1, 4));
      if (p == 3) random_group(MAX_GROUP_DEFAULT);
      while (items_sent - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 39))
          0:       len = MAX_GROUP_DEFAULT + $urandom_range(0, 3);
          1, 2:    len = $urandom_range(9, 24);
          3, 4, 5: len = 1;
          default: len = $urandom_range(2, 8);
        endcase
        random_group(len);
      end
    end

    wait_idle();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ group_soft_threshold_unit.f @@
design/gst_pkg.sv
design/group_soft_threshold_unit.sv
dv/group_soft_threshold_checker.sv
dv/testbench.sv
